/* rtl/mau_pkg.sv */
// ----------------------------------------------------------------------------
// mau_pkg
// Types and constants for the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int FIELD_W   = 32;
  localparam int MOD_RESET = 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_EQU = 3'd5,
    OP_INC = 3'd6,
    OP_DEC = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_EXEC,
    S_MUL,
    S_EUC_CHK,
    S_EUC_DIV,
    S_EUC_UPD,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t                opcode;
    logic [FIELD_W-1:0] operand_a;
    logic [FIELD_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result;
    logic               is_equal;
    logic               no_inverse;
  } out_item_t;

endpackage

/* rtl/modular_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Add, subtract, multiply, divide, negate, compare, increment and decrement
// modulo a configured modulus.
// ----------------------------------------------------------------------------
// One item at a time. Both operands are reduced bit-serially, then S_EXEC
// decodes the operation and S_OUT hands the result to the output register.
// Add, sub, negate, compare, inc and dec go straight from S_EXEC to S_OUT.
// Multiply adds a double-and-add loop in S_MUL. Divide first runs the extended
// Euclidean algorithm: each Euclid step is a restoring division sharing its
// quotient bits with a modular multiply-accumulate, and the number of steps
// depends on the operands; the final multiply follows. A new item is
// taken while the previous result still waits in the output register.
module modular_arithmetic_unit #(
  parameter int WIDTH = mau_pkg::WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mau_pkg::FIELD_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mau_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mau_pkg::out_item_t               out_data
);
  import mau_pkg::*;

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0]    CNT_LAST = CW'(WIDTH - 1);
  localparam logic [CW-1:0]    CNT_ZERO = '0;
  localparam logic [CW-1:0]    CNT_ONE  = CW'(1);
  localparam logic [WIDTH-1:0] MOD_MIN  = WIDTH'(MOD_RESET);
  localparam logic [WIDTH-1:0] ONE      = WIDTH'(1);

  function automatic logic [WIDTH-1:0] add_m(input logic [WIDTH-1:0] a,
                                             input logic [WIDTH-1:0] b,
                                             input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] gap;
    gap = m - b;
    return (a >= gap) ? a - gap : a + b;
  endfunction

  function automatic logic [WIDTH-1:0] sub_m(input logic [WIDTH-1:0] a,
                                             input logic [WIDTH-1:0] b,
                                             input logic [WIDTH-1:0] m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  function automatic logic [WIDTH:0] div_step(input logic [WIDTH-1:0] rem,
                                              input logic             bin,
                                              input logic [WIDTH-1:0] d);
    logic [WIDTH:0] sh;
    logic [WIDTH:0] diff;
    sh   = {rem, bin};
    diff = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      return {1'b1, diff[WIDTH-1:0]};
    end
    return {1'b0, sh[WIDTH-1:0]};
  endfunction

  state_t state, state_next;

  logic [WIDTH-1:0] modv, m;
  op_t              opc;
  logic [WIDTH-1:0] sa, sb, ra, rb, re;
  logic [WIDTH-1:0] r0, r1, t0, t1, acc, x, y;
  logic             qbit, ph;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] res;
  logic             eq, ni;
  logic             load_out;

  logic [WIDTH:0]       ds_a, ds_b, ds_e;
  logic [WIDTH-1:0]     acc_dbl, acc_add_x, acc_add_t;
  logic [WIDTH+FIELD_W-1:0] ext_a, ext_b, ext_c, ext_r;

  assign m = (modv < MOD_MIN) ? MOD_MIN : modv;

  assign ext_a = {{WIDTH{1'b0}}, in_data.operand_a};
  assign ext_b = {{WIDTH{1'b0}}, in_data.operand_b};
  assign ext_c = {{WIDTH{1'b0}}, cfg_data};
  assign ext_r = {{FIELD_W{1'b0}}, res};

  assign ds_a      = div_step(ra, sa[WIDTH-1], m);
  assign ds_b      = div_step(rb, sb[WIDTH-1], m);
  assign ds_e      = div_step(re, sa[WIDTH-1], r1);
  assign acc_dbl   = add_m(acc, acc, m);
  assign acc_add_x = add_m(acc, x, m);
  assign acc_add_t = add_m(acc, t1, m);

  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_RED;
      S_RED:     if (cnt == CNT_ZERO) state_next = S_EXEC;
      S_EXEC: begin
        if (opc == OP_MUL) begin
          state_next = S_MUL;
        end else if (opc == OP_DIV) begin
          state_next = S_EUC_CHK;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MUL:     if (ph && cnt == CNT_ZERO) state_next = S_OUT;
      S_EUC_CHK: begin
        if (r1 != '0) begin
          state_next = S_EUC_DIV;
        end else if (r0 == ONE) begin
          state_next = S_MUL;
        end else begin
          state_next = S_OUT;
        end
      end
      S_EUC_DIV: if (ph && cnt == CNT_ZERO) state_next = S_EUC_UPD;
      S_EUC_UPD: state_next = S_EUC_CHK;
      S_OUT:     if (!out_valid || out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    load_out = (state == S_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      modv      <= MOD_MIN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        modv <= ext_c[WIDTH-1:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.result     <= ext_r[FIELD_W-1:0];
      out_data.is_equal   <= eq;
      out_data.no_inverse <= ni;
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          opc <= in_data.opcode;
          sa  <= ext_a[WIDTH-1:0];
          sb  <= ext_b[WIDTH-1:0];
          ra  <= '0;
          rb  <= '0;
          cnt <= CNT_LAST;
        end
      end
      S_RED: begin
        ra  <= ds_a[WIDTH-1:0];
        rb  <= ds_b[WIDTH-1:0];
        sa  <= sa << 1;
        sb  <= sb << 1;
        cnt <= cnt - CNT_ONE;
      end
      S_EXEC: begin
        res <= '0;
        eq  <= 1'b0;
        ni  <= 1'b0;
        acc <= '0;
        ph  <= 1'b0;
        cnt <= CNT_LAST;
        x   <= ra;
        y   <= rb;
        r0  <= m;
        r1  <= rb;
        t0  <= '0;
        t1  <= ONE;
        case (opc)
          OP_ADD:  res <= add_m(ra, rb, m);
          OP_SUB:  res <= sub_m(ra, rb, m);
          OP_NEG:  res <= (ra == '0) ? '0 : m - ra;
          OP_EQU:  eq  <= (ra == rb);
          OP_INC:  res <= add_m(ra, ONE, m);
          OP_DEC:  res <= sub_m(ra, ONE, m);
          default: res <= '0;
        endcase
      end
      S_MUL: begin
        if (!ph) begin
          acc <= acc_dbl;
          ph  <= 1'b1;
        end else begin
          acc <= y[WIDTH-1] ? acc_add_x : acc;
          res <= y[WIDTH-1] ? acc_add_x : acc;
          y   <= y << 1;
          ph  <= 1'b0;
          cnt <= cnt - CNT_ONE;
        end
      end
      S_EUC_CHK: begin
        acc <= '0;
        ph  <= 1'b0;
        cnt <= CNT_LAST;
        re  <= '0;
        sa  <= r0;
        x   <= ra;
        y   <= t0;
        if (r1 == '0 && r0 != ONE) begin
          ni  <= 1'b1;
          res <= '0;
        end
      end
      S_EUC_DIV: begin
        if (!ph) begin
          re   <= ds_e[WIDTH-1:0];
          qbit <= ds_e[WIDTH];
          sa   <= sa << 1;
          acc  <= acc_dbl;
          ph   <= 1'b1;
        end else begin
          if (qbit) begin
            acc <= acc_add_t;
          end
          ph  <= 1'b0;
          cnt <= cnt - CNT_ONE;
        end
      end
      S_EUC_UPD: begin
        r0 <= r1;
        r1 <= re;
        t0 <= t1;
        t1 <= sub_m(t0, acc, m);
      end
      default: begin
      end
    endcase
  end

endmodule

/* bench/modular_arithmetic_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_tb
// Drives operation items through the modular arithmetic unit under a series
// of moduli (degenerate, small, prime, composite, full width), predicts each
// result in the bench and checks every output transfer against it.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_tb;
  import mau_pkg::*;

  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int STALL_LIMIT = 20000;

  logic      clk;
  logic      rst;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [FIELD_W-1:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];
  logic [FIELD_W-1:0] active_mod;
  logic      in_taken;
  int        src_idle_pct;
  int        snk_idle_pct;
  int        error_count;
  int        stall_cycles;

  modular_arithmetic_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint unsigned eff_modulus(logic [FIELD_W-1:0] reg_val);
    return (reg_val < 2) ? 64'd2 : {32'd0, reg_val};
  endfunction

  function automatic out_item_t mod_compute(in_item_t item);
    longint unsigned m;
    longint unsigned a;
    longint unsigned b;
    longint unsigned r;
    longint r0, r1, r2, t0, t1, t2, q;
    out_item_t res;
    m = eff_modulus(active_mod);
    a = {32'd0, item.operand_a} % m;
    b = {32'd0, item.operand_b} % m;
    r = 0;
    res = '0;
    case (item.opcode)
      OP_ADD: r = (a + b) % m;
      OP_SUB: r = (a >= b) ? a - b : a + (m - b);
      OP_MUL: r = (a * b) % m;
      OP_DIV: begin
        r0 = longint'(m);
        r1 = longint'(b);
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
          q  = r0 / r1;
          r2 = r0 - q * r1;
          t2 = t0 - q * t1;
          r0 = r1;
          r1 = r2;
          t0 = t1;
          t1 = t2;
        end
        if (r0 != 1) begin
          res.no_inverse = 1'b1;
        end else begin
          t0 = t0 % longint'(m);
          if (t0 < 0) t0 = t0 + longint'(m);
          r = (a * longint'(t0)) % m;
        end
      end
      OP_NEG: r = (a == 0) ? 0 : m - a;
      OP_EQU: res.is_equal = (a == b);
      OP_INC: r = (a + 1) % m;
      default: r = (a == 0) ? m - 1 : a - 1;
    endcase
    res.result = r[FIELD_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                 logic [FIELD_W-1:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // input channel driver and output ready generator
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_ops[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken  <= 1'b0;
    out_ready <= !rst && ($urandom_range(99) >= snk_idle_pct);
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(mod_compute(in_data));
        void'(pending_ops.pop_front());
        in_taken <= 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result %0h at %0t", out_data.result, $realtime);
          error_count++;
        end else begin
          out_item_t want;
          want = expected_results.pop_front();
          if (out_data.result !== want.result)
            report_mismatch("result", out_data.result, want.result);
          if (out_data.is_equal !== want.is_equal)
            report_mismatch("is_equal", out_data.is_equal, want.is_equal);
          if (out_data.no_inverse !== want.no_inverse)
            report_mismatch("no_inverse", out_data.no_inverse, want.no_inverse);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("modular_arithmetic_unit_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic write_modulus(logic [FIELD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    active_mod = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_op(op_t op, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
    in_item_t item;
    item.opcode    = op;
    item.operand_a = a;
    item.operand_b = b;
    pending_ops.push_back(item);
  endtask

  function automatic logic [FIELD_W-1:0] pick_operand(logic [FIELD_W-1:0] mval);
    logic [FIELD_W-1:0] v;
    case ($urandom_range(7))
      0:       v = $urandom_range(3);
      1:       v = mval - $urandom_range(2) + $urandom_range(2);
      2:       v = mval * $urandom_range(3);
      3:       v = 32'hFFFF_FFFF - $urandom_range(3);
      4:       v = $urandom_range(1, 40) * (2 + $urandom_range(3));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [FIELD_W-1:0] mods[NUM_PHASES];
    logic [FIELD_W-1:0] p;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    in_taken     = 1'b0;
    active_mod   = MOD_RESET;
    src_idle_pct = 31;
    snk_idle_pct = 67;
    error_count  = 0;
    stall_cycles = 0;
    mods = '{32'hFFFF_FFFB, 32'd0, 32'd1, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000,
             32'd97, 32'd2, 32'd360, 32'd0, 32'd0, 32'h7FFF_FFFF};
    mods[9]  = $urandom;
    mods[10] = $urandom_range(4, 5000);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset modulus before any write
    push_op(OP_ADD, 32'd1, 32'd1);
    push_op(OP_DIV, 32'd3, 32'd5);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 4) begin
        src_idle_pct = 67;
        snk_idle_pct = 31;
      end else if (ph == 8) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      write_modulus(mods[ph]);
      if (ph == 0) begin
        p = mods[0];
        for (int o = 0; o < 8; o++) begin
          push_op(op_t'(o), 32'hFFFF_FFFF, p - 1);
          push_op(op_t'(o), 32'd0, p);
        end
        push_op(OP_DIV, 32'd7, 32'd0);
        push_op(OP_DIV, p - 1, p - 1);
        push_op(OP_EQU, 32'd5, p + 5);
        push_op(OP_NEG, 32'd0, 32'd9);
        push_op(OP_INC, p - 1, 32'd0);
        push_op(OP_DEC, 32'd0, 32'd0);
        push_op(OP_MUL, p - 1, p - 1);
        push_op(OP_SUB, 32'd0, 32'd1);
      end
      p = (mods[ph] < 2) ? 32'd2 : mods[ph];
      for (int i = 0; i < PHASE_ITEMS; i++)
        push_op(op_t'($urandom_range(7)), pick_operand(p), pick_operand(p));
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("modular_arithmetic_unit_tb: PASS");
    end else begin
      $display("modular_arithmetic_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
